// ===== hw/rtl/spmq_pkg.sv =====
// Shared types and codes for the shared-pool multi-queue unit.
`default_nettype none
package spmq_pkg;

  localparam int FUNC_W   = 2;
  localparam int QID_W    = 3;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int QUSE_W   = 4;
  localparam int LIMIT_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_TAIL = 2'd0,
    FN_PUSH_HEAD = 2'd1,
    FN_POP_HEAD  = 2'd2,
    FN_QUERY     = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUEUES_IN_USE = 2'd0,
    REG_FILL_LIMIT    = 2'd1,
    REG_UNLIMITED     = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_POP
  } state_t;

  // write strobes for the slot pool memories
  typedef struct packed {
    logic nxt_we;
    logic pay_we;
  } pool_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spmq_pool.sv =====
// Slot pool: payload and next-pointer memories, one shared read address.
`default_nettype none
module spmq_pool #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 64,
  parameter int SW         = 8
) (
  input  logic                  clk,
  input  spmq_pkg::pool_wr_t    wr,
  input  logic [SW-1:0]         rd_addr,
  input  logic [SW-1:0]         nxt_waddr,
  input  logic [SW-1:0]         nxt_wdata,
  input  logic [SW-1:0]         pay_waddr,
  input  logic [DATA_WIDTH-1:0] pay_wdata,
  output logic [SW-1:0]         rd_next,
  output logic [DATA_WIDTH-1:0] rd_payload
);
  import spmq_pkg::*;

  logic [DATA_WIDTH-1:0] pay_mem [CAPACITY];
  logic [SW-1:0]         nxt_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    rd_payload <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    rd_next <= nxt_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shared_pool_multi_queue_unit.sv =====
// Top level: several linked-list queues over one shared slot pool.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------------
//  request   | start / busy           | func, queue_id, item_data
//  result    | done (1-cycle strobe)  | status, popped_data, queue_empty, all_empty,
//            |                        | is_full, item_count
//  config    | cfg_we                 | cfg_index, cfg_wdata
//
// Push, query and refused requests finish in the read state (S_RD); a pop goes on to S_POP,
// since the head slot is read from the pool only after the queue table read returns. Results
// are registered. A new request can be accepted in the cycle done is high.
// Reset clears queue occupancy, the free list and the counters; the pool memories
// and the queue pointer table need no clearing. Results cannot be stalled.
`default_nettype none
module shared_pool_multi_queue_unit #(
  parameter int NUM_QUEUES = 8,
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [spmq_pkg::FUNC_W-1:0]       func,
  input  logic [spmq_pkg::QID_W-1:0]        queue_id,
  input  logic [spmq_pkg::WORD_W-1:0]       item_data,
  output logic                              done,
  output logic [spmq_pkg::STATUS_W-1:0]     status,
  output logic [spmq_pkg::WORD_W-1:0]       popped_data,
  output logic                              queue_empty,
  output logic                              all_empty,
  output logic                              is_full,
  output logic [spmq_pkg::COUNT_W-1:0]      item_count,
  input  logic                              cfg_we,
  input  logic [spmq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spmq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import spmq_pkg::*;

  localparam int SW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int MW  = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
  localparam logic [6:0]    NQ7 = 7'(NUM_QUEUES);

  // config registers
  logic [QUSE_W-1:0]  queues_in_use;
  logic [LIMIT_W-1:0] fill_limit;
  logic               unlimited;

  // control state
  state_t             state, state_next;
  logic [NUM_QUEUES-1:0] q_nonempty;
  logic [SW-1:0]      free_head;
  logic [CW-1:0]      fresh_used;
  logic [CW-1:0]      total_count;

  // latched request
  func_e              op_func;
  logic [QID_W-1:0]   op_q;
  logic [DATA_WIDTH-1:0] op_data;
  logic               op_valid;

  // queue pointer table {head, tail}
  logic [2*SW-1:0]    qtab [NUM_QUEUES];
  logic [2*SW-1:0]    qtab_rd;
  logic               qtab_we;
  logic [2*SW-1:0]    qtab_wdata;

  // pool interface
  pool_wr_t           pool_wr;
  logic [SW-1:0]      pool_rd_addr;
  logic [SW-1:0]      nxt_waddr, nxt_wdata, pay_waddr;
  logic [SW-1:0]      rd_next;
  logic [DATA_WIDTH-1:0] rd_payload;

  // combinational results
  logic               accept;
  logic [QIW-1:0]     qidx;
  logic [SW-1:0]      cur_head, cur_tail, new_slot;
  logic               take_free, limit_hit, cap_hit, cur_nonempty, do_push;
  logic               res_fire, res_qempty;
  status_e            res_status;
  logic [CW-1:0]      res_count;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign qidx     = QIW'(op_q);
  assign cur_head = qtab_rd[2*SW-1:SW];
  assign cur_tail = qtab_rd[SW-1:0];
  assign cur_nonempty = q_nonempty[qidx];
  assign take_free = total_count < fresh_used;
  assign new_slot  = take_free ? free_head : fresh_used[SW-1:0];
  assign limit_hit = !unlimited && (MW'(total_count) >= MW'(fill_limit));
  assign cap_hit   = total_count >= CAP_COUNT;
  assign do_push   = (state == S_RD) && op_valid && !limit_hit && !cap_hit &&
                     ((op_func == FN_PUSH_TAIL) || (op_func == FN_PUSH_HEAD));

  spmq_pool #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .SW         (SW)
  ) u_pool (
    .clk        (clk),
    .wr         (pool_wr),
    .rd_addr    (pool_rd_addr),
    .nxt_waddr  (nxt_waddr),
    .nxt_wdata  (nxt_wdata),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (op_data),
    .rd_next    (rd_next),
    .rd_payload (rd_payload)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    pool_rd_addr = free_head;
    pool_wr      = '0;
    nxt_waddr    = cur_tail;
    nxt_wdata    = new_slot;
    pay_waddr    = new_slot;
    qtab_we      = 1'b0;
    qtab_wdata   = qtab_rd;
    res_fire     = 1'b0;
    res_status   = ST_OK;
    res_count    = total_count;
    res_qempty   = 1'b1;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (op_valid && (op_func == FN_POP_HEAD) && cur_nonempty) begin
          state_next   = S_POP;
          pool_rd_addr = cur_head;
        end else begin
          state_next = S_IDLE;
          res_fire   = 1'b1;
          res_qempty = !op_valid || !cur_nonempty;
          if (!op_valid) begin
            res_status = ST_BAD_ID;
          end else if (op_func == FN_POP_HEAD) begin
            res_status = ST_EMPTY;
          end else if (op_func != FN_QUERY) begin
            if (limit_hit || cap_hit) begin
              res_status = ST_FULL;
            end else begin
              res_count      = total_count + 1'b1;
              res_qempty     = 1'b0;
              pool_wr.pay_we = 1'b1;
              qtab_we        = 1'b1;
              if (!cur_nonempty) begin
                qtab_wdata = {new_slot, new_slot};
              end else if (op_func == FN_PUSH_TAIL) begin
                pool_wr.nxt_we = 1'b1;
                nxt_waddr      = cur_tail;
                nxt_wdata      = new_slot;
                qtab_wdata     = {cur_head, new_slot};
              end else begin
                pool_wr.nxt_we = 1'b1;
                nxt_waddr      = new_slot;
                nxt_wdata      = cur_head;
                qtab_wdata     = {new_slot, cur_tail};
              end
            end
          end
        end
      end
      S_POP: begin
        state_next     = S_IDLE;
        res_fire       = 1'b1;
        res_count      = total_count - 1'b1;
        res_qempty     = (cur_head == cur_tail);
        // freed slot goes to the front of the free list
        pool_wr.nxt_we = 1'b1;
        nxt_waddr      = cur_head;
        nxt_wdata      = free_head;
        qtab_we        = (cur_head != cur_tail);
        qtab_wdata     = {rd_next, cur_tail};
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // request latch and queue table
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= func_e'(func);
      op_q     <= queue_id;
      op_data  <= DATA_WIDTH'(item_data);
      op_valid <= ({1'b0, queue_id} < queues_in_use) && (7'(queue_id) < NQ7);
      qtab_rd  <= qtab[QIW'(queue_id)];
    end
    if (qtab_we) begin
      qtab[qidx] <= qtab_wdata;
    end
  end

  // occupancy, free list and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      q_nonempty  <= '0;
      free_head   <= '0;
      fresh_used  <= '0;
      total_count <= '0;
    end else begin
      if (do_push) begin
        q_nonempty[qidx] <= 1'b1;
        if (take_free) begin
          free_head <= rd_next;
        end else begin
          fresh_used <= fresh_used + 1'b1;
        end
      end
      if (state == S_POP) begin
        q_nonempty[qidx] <= (cur_head != cur_tail);
        free_head        <= cur_head;
      end
      if (res_fire) begin
        total_count <= res_count;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_fire;
    end
    if (res_fire) begin
      status      <= res_status;
      popped_data <= (state == S_POP) ? WORD_W'(rd_payload) : '0;
      queue_empty <= res_qempty;
      all_empty   <= (res_count == '0);
      is_full     <= !unlimited && (MW'(res_count) == MW'(fill_limit));
      item_count  <= COUNT_W'(res_count);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use <= QUSE_W'(8);
      fill_limit    <= LIMIT_W'(256);
      unlimited     <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_e'(cfg_index))
        REG_QUEUES_IN_USE: queues_in_use <= cfg_wdata[QUSE_W-1:0];
        REG_FILL_LIMIT:    fill_limit    <= cfg_wdata[LIMIT_W-1:0];
        REG_UNLIMITED:     unlimited     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spmq_checker.sv =====
// Port-level checks for the shared-pool multi-queue unit, bound to the top level.
`default_nettype none
module spmq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [spmq_pkg::STATUS_W-1:0] status,
  input wire logic [spmq_pkg::WORD_W-1:0]   popped_data,
  input wire logic                          queue_empty,
  input wire logic                          all_empty,
  input wire logic [spmq_pkg::COUNT_W-1:0]  item_count
);
  import spmq_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_all_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> (all_empty == (item_count == '0)))
    else $error("all_empty disagrees with item_count");

  a_no_data: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (popped_data == '0))
    else $error("refused item returned data");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done && ((status == ST_EMPTY) || (status == ST_BAD_ID)) |-> queue_empty)
    else $error("empty or invalid queue reported as holding items");

endmodule

bind shared_pool_multi_queue_unit spmq_checker u_spmq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .popped_data (popped_data),
  .queue_empty (queue_empty),
  .all_empty   (all_empty),
  .item_count  (item_count)
);
`default_nettype wire
